/* rtl/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared constants, opcodes and beat layouts of the task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int TASK_COUNT = 8;
    localparam int IDX_W      = $clog2(TASK_COUNT);

    localparam int OPCODE_W   = 2;
    localparam int TASK_W     = 3;
    localparam int WORD_W     = 32;

    localparam int S_FIELDS_W = WORD_W + WORD_W + TASK_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;

    localparam int M_FIELDS_W = TASK_W + WORD_W + 1 + WORD_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK   = 2'd0,
        OP_DELAY  = 2'd1,
        OP_SWITCH = 2'd2,
        OP_LOAD   = 2'd3
    } opcode_t;

endpackage

/* rtl/round_robin_task_scheduler.sv */
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Tick counter, delay blocking, per-task stack pointers and round-robin selection of the next task.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one output beat. A delay or load beat goes
// from the idle state to the finish state, which writes the output register.
// A tick beat passes through the tick state and a switch beat through the
// switch state before the finish state, because one wake-time comparator and
// one readiness test walk the task table one entry per cycle. The finish state
// waits while the output register holds a beat not yet taken, then writes the
// result and returns to the idle state. The block is not ready while a beat is
// in progress, but a finished result waits in the output register while the
// next beat is taken.
module round_robin_task_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // delay_ticks, stack_pointer_in, task_index, zero padding
    input  logic [rrts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic [rrts_pkg::OPCODE_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // running_task, stack_pointer_out, switch_requested, tick_now, zero padding
    output logic [rrts_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = rrts_pkg::IDX_W;
    localparam int NTASK = rrts_pkg::TASK_COUNT;
    localparam int WW    = rrts_pkg::WORD_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NTASK - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SWITCH,
        ST_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          cur_reg, cur_next;
    logic [WW-1:0]             tick_reg, tick_next;
    logic [NTASK-1:0]          blocked_reg, blocked_next;
    logic [IDX_W-1:0]          walk_idx_reg, walk_idx_next;
    logic [IDX_W-1:0]          walk_cnt_reg, walk_cnt_next;
    logic                      req_reg, req_next;
    logic                      out_valid_reg, out_valid_next;

    logic [WW-1:0]             sp_reg   [NTASK];
    logic [WW-1:0]             sp_next  [NTASK];
    logic [WW-1:0]             wake_reg [NTASK];
    logic [WW-1:0]             wake_next[NTASK];

    logic [rrts_pkg::TASK_W-1:0] out_task_reg, out_task_next;
    logic [WW-1:0]             out_sp_reg, out_sp_next;
    logic                      out_req_reg, out_req_next;
    logic [WW-1:0]             out_tick_reg, out_tick_next;

    rrts_pkg::opcode_t         in_op;
    logic [WW-1:0]             in_delay;
    logic [WW-1:0]             in_sp;
    logic [rrts_pkg::TASK_W-1:0] in_task;
    logic [IDX_W-1:0]          cur_succ;
    logic [IDX_W-1:0]          walk_succ;

    assign in_op    = rrts_pkg::opcode_t'(s_axis_tuser);
    assign in_delay = s_axis_tdata[WW-1:0];
    assign in_sp    = s_axis_tdata[2*WW-1:WW];
    assign in_task  = s_axis_tdata[2*WW+rrts_pkg::TASK_W-1:2*WW];

    assign cur_succ  = (cur_reg == LAST_IDX) ? '0 : cur_reg + IDX_W'(1);
    assign walk_succ = (walk_idx_reg == LAST_IDX) ? '0 : walk_idx_reg + IDX_W'(1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{rrts_pkg::M_PAD_W{1'b0}}, out_tick_reg, out_req_reg,
                            out_sp_reg, out_task_reg};

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        tick_next      = tick_reg;
        blocked_next   = blocked_reg;
        walk_idx_next  = walk_idx_reg;
        walk_cnt_next  = walk_cnt_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;
        sp_next        = sp_reg;
        wake_next      = wake_reg;
        out_task_next  = out_task_reg;
        out_sp_next    = out_sp_reg;
        out_req_next   = out_req_reg;
        out_tick_next  = out_tick_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (in_op)
                        rrts_pkg::OP_TICK:
                        begin
                            tick_next     = tick_reg + WW'(1);
                            req_next      = 1'b1;
                            walk_idx_next = IDX_W'(1);
                            state_next    = ST_TICK;
                        end
                        rrts_pkg::OP_DELAY:
                        begin
                            req_next = 1'b0;
                            if (cur_reg != '0)
                            begin
                                wake_next[cur_reg]    = tick_reg + in_delay;
                                blocked_next[cur_reg] = 1'b1;
                                req_next              = 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        rrts_pkg::OP_SWITCH:
                        begin
                            sp_next[cur_reg] = in_sp;
                            walk_idx_next    = cur_succ;
                            walk_cnt_next    = '0;
                            req_next         = 1'b0;
                            state_next       = ST_SWITCH;
                        end
                        rrts_pkg::OP_LOAD:
                        begin
                            if (int'(in_task) < NTASK)
                            begin
                                sp_next[IDX_W'(in_task)] = in_sp;
                            end
                            req_next   = 1'b0;
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            req_next   = 1'b0;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (blocked_reg[walk_idx_reg] && (wake_reg[walk_idx_reg] <= tick_reg))
                begin
                    blocked_next[walk_idx_reg] = 1'b0;
                end
                if (walk_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    walk_idx_next = walk_succ;
                end
            end
            ST_SWITCH:
            begin
                if ((walk_idx_reg != '0) && !blocked_reg[walk_idx_reg])
                begin
                    cur_next   = walk_idx_reg;
                    state_next = ST_FINISH;
                end
                else if (walk_cnt_reg == LAST_IDX)
                begin
                    cur_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    walk_idx_next = walk_succ;
                    walk_cnt_next = walk_cnt_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_task_next  = rrts_pkg::TASK_W'(cur_reg);
                    out_sp_next    = sp_reg[cur_reg];
                    out_req_next   = req_reg;
                    out_tick_next  = tick_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= IDX_W'(1);
            tick_reg      <= '0;
            blocked_reg   <= '0;
            walk_idx_reg  <= '0;
            walk_cnt_reg  <= '0;
            req_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            tick_reg      <= tick_next;
            blocked_reg   <= blocked_next;
            walk_idx_reg  <= walk_idx_next;
            walk_cnt_reg  <= walk_cnt_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sp_reg       <= sp_next;
        wake_reg     <= wake_next;
        out_task_reg <= out_task_next;
        out_sp_reg   <= out_sp_next;
        out_req_reg  <= out_req_next;
        out_tick_reg <= out_tick_next;
    end

endmodule

/* rtl/rrts_checker.sv */
// ----------------------------------------------------------------------------
// Round-robin task scheduler checker
// Port-level assertions on the scheduler, attached to the scheduler module by bind.
// ----------------------------------------------------------------------------
module rrts_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [rrts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [rrts_pkg::OPCODE_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rrts_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int PAD_LO = rrts_pkg::M_FIELDS_W;

    a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("Waiting input beat changed before it was taken.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output beat withdrawn before it was taken.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Stalled output beat changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Scheduler took a second beat while one was in progress.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[rrts_pkg::M_TDATA_W-1:PAD_LO] == '0))
        else $error("Padding bits of the output beat are not zero.");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
